/* sv/kpbm_pkg.sv */
// ----------------------------------------------------------------------------
// kpbm_pkg: key to player button mapper package
// Item codes, result codes and the key table entry layout.
// ----------------------------------------------------------------------------
package kpbm_pkg;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_EVENT = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_MISS       = 2'd1,
    ST_FULL       = 2'd2,
    ST_BAD_PLAYER = 2'd3
  } status_t;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned PlayerW = 4;
  localparam int unsigned BtnW    = 8;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [PlayerW-1:0] player;
    logic [BtnW-1:0]    mask;
    logic               pressed;
  } entry_t;

endpackage

/* sv/key_to_player_button_mapper_unit.sv */
// ----------------------------------------------------------------------------
// key_to_player_button_mapper_unit: key code to player button mapper
// Key table with linear search, per-player button words and aggregate word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item: add a key
//   mapping, report a key event, or query a player's buttons. Output channel
//   (out_valid/out_ready) returns exactly one beat per item with status,
//   the affected player's buttons and the aggregate (player 0) buttons.
//   A query, a bad-player add or an unused beat is staged and then loaded
//   into the output register, and the next beat is taken once the unit is
//   idle again. An add or key event searches the key table one entry per
//   cycle through the RAM read port (registered read data); a key event
//   hit then updates the button words before the result is staged and
//   registered. The linear search over the table RAM sets the rate;
//   in_ready is low until the item's result has been loaded into the
//   output register.
//   Reset clears the entry count, all player button words and the output
//   valid. Table RAM contents are not cleared; entries beyond the count are
//   never compared, so no clearing pass is needed.
//   If the receiver stalls, the finished result waits in its staging
//   registers until the output register frees, and no new item is taken.
// ----------------------------------------------------------------------------
module key_to_player_button_mapper_unit #(
  parameter int unsigned TABLE_DEPTH  = 32,
  parameter int unsigned PLAYER_COUNT = 8,
  parameter int unsigned BUTTON_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] key_code,
  input  logic [3:0]  player,
  input  logic [7:0]  button_mask,
  input  logic        pressed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  player_buttons,
  output logic [7:0]  any_buttons
);

  import kpbm_pkg::*;

  // table address and count widths
  localparam int unsigned AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PIDX_W = $clog2(PLAYER_COUNT + 1);
  localparam int unsigned EW     = $bits(entry_t);
  localparam logic [BtnW-1:0] BtnMask =
    (BUTTON_BITS >= BtnW) ? {BtnW{1'b1}} : BtnW'((64'd1 << BUTTON_BITS) - 64'd1);
  localparam logic [CW-1:0]      DepthC  = CW'(TABLE_DEPTH);
  localparam logic [PlayerW-1:0] MaxPlay = PlayerW'(PLAYER_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_RESULT
  } state_t;

  state_t              state;
  action_t             action_r;
  logic [KeyW-1:0]     key_r;
  logic [PlayerW-1:0]  player_r;
  logic [BtnW-1:0]     mask_r;
  logic                pressed_r;

  logic [CW-1:0]       entry_count;
  logic [CW-1:0]       issue_idx;
  logic [CW-1:0]       cmp_idx;
  logic                cmp_vld;
  entry_t              hit_entry;
  logic [AW-1:0]       hit_idx;

  logic [BtnW-1:0]     player_state [PLAYER_COUNT+1];

  status_t             res_status;
  logic [BtnW-1:0]     res_pbtn;

  // RAM signals
  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  entry_t              ram_wr_data;
  logic [EW-1:0]       ram_rd_raw;
  entry_t              ram_rd_data;

  // search and update datapath
  logic                issue_more;
  logic                hit;
  logic                miss;
  logic                table_full;
  logic [PIDX_W-1:0]   add_pidx;
  logic [PIDX_W-1:0]   ev_pidx;
  logic [BtnW-1:0]     ps_p;
  logic                rise;
  logic                fall;
  logic [BtnW-1:0]     new_p;
  logic [BtnW-1:0]     new_0;
  logic                out_free;

  assign ram_rd_data = entry_t'(ram_rd_raw);
  assign issue_more  = issue_idx < entry_count;
  assign hit         = (state == S_SEARCH) && cmp_vld && (ram_rd_data.key == key_r);
  assign miss        = (state == S_SEARCH) && !cmp_vld && !issue_more;
  assign table_full  = entry_count >= DepthC;
  assign add_pidx    = player_r[PIDX_W-1:0];
  assign ev_pidx     = (hit_entry.player <= MaxPlay) ? hit_entry.player[PIDX_W-1:0]
                                                     : '0;
  assign ps_p        = player_state[ev_pidx];
  assign rise        = pressed_r && !hit_entry.pressed;
  assign fall        = !pressed_r && hit_entry.pressed;
  assign new_p       = rise ? ((ps_p | hit_entry.mask) & BtnMask)
                     : fall ? (ps_p & ~hit_entry.mask & BtnMask) : ps_p;
  assign new_0       = rise ? ((player_state[0] | hit_entry.mask) & BtnMask)
                     : fall ? (player_state[0] & ~hit_entry.mask & BtnMask)
                            : player_state[0];
  assign out_free    = !out_valid || out_ready;
  assign in_ready    = (state == S_IDLE);

  // RAM write: new entry on an add miss, pressed flag on a level change
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = entry_count[AW-1:0];
    ram_wr_data = '{key: key_r, player: player_r, mask: mask_r & BtnMask,
                    pressed: 1'b0};
    if (miss && (action_r == ACT_ADD) && !table_full) begin
      ram_wr_en = 1'b1;
    end else if ((state == S_UPDATE) && (rise || fall)) begin
      ram_wr_en           = 1'b1;
      ram_wr_addr         = hit_idx;
      ram_wr_data         = hit_entry;
      ram_wr_data.pressed = pressed_r;
    end
  end

  kpbm_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (issue_idx[AW-1:0]),
    .rd_data (ram_rd_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      issue_idx   <= '0;
      cmp_vld     <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i <= PLAYER_COUNT; i++) begin
        player_state[i] <= '0;
      end
    end else begin
      // output beat: loaded from staging, or dropped once taken
      if ((state == S_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            action_r  <= action_t'(action);
            key_r     <= key_code;
            player_r  <= player;
            mask_r    <= button_mask;
            pressed_r <= pressed;
            issue_idx <= '0;
            cmp_vld   <= 1'b0;
            case (action_t'(action))
              ACT_ADD: begin
                if (player > MaxPlay) begin
                  res_status <= ST_BAD_PLAYER;
                  res_pbtn   <= '0;
                  state      <= S_RESULT;
                end else begin
                  state <= S_SEARCH;
                end
              end
              ACT_EVENT: begin
                state <= S_SEARCH;
              end
              ACT_QUERY: begin
                if (player > MaxPlay) begin
                  res_status <= ST_BAD_PLAYER;
                  res_pbtn   <= '0;
                end else begin
                  res_status <= ST_DONE;
                  res_pbtn   <= player_state[player[PIDX_W-1:0]];
                end
                state <= S_RESULT;
              end
              default: begin
                res_status <= ST_MISS;
                res_pbtn   <= '0;
                state      <= S_RESULT;
              end
            endcase
          end
        end
        S_SEARCH: begin
          // one read issued and one compare made per cycle
          if (hit) begin
            hit_entry <= ram_rd_data;
            hit_idx   <= cmp_idx[AW-1:0];
            if (action_r == ACT_ADD) begin
              res_status <= ST_MISS;
              res_pbtn   <= player_state[add_pidx];
              state      <= S_RESULT;
            end else begin
              state <= S_UPDATE;
            end
          end else if (miss) begin
            if (action_r == ACT_ADD) begin
              res_pbtn <= player_state[add_pidx];
              if (table_full) begin
                res_status <= ST_FULL;
              end else begin
                res_status  <= ST_DONE;
                entry_count <= entry_count + CW'(1);
              end
            end else begin
              res_status <= ST_MISS;
              res_pbtn   <= '0;
            end
            state <= S_RESULT;
          end else begin
            cmp_vld <= issue_more;
            cmp_idx <= issue_idx;
            if (issue_more) begin
              issue_idx <= issue_idx + CW'(1);
            end
          end
        end
        S_UPDATE: begin
          // a key mapped to player 0 moves the aggregate word only
          if (ev_pidx != '0) begin
            player_state[ev_pidx] <= new_p;
          end
          player_state[0] <= new_0;
          res_status      <= ST_DONE;
          res_pbtn        <= new_p;
          state           <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            status         <= res_status;
            player_buttons <= res_pbtn;
            any_buttons    <= player_state[0];
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/kpbm_ram.sv */
// ----------------------------------------------------------------------------
// kpbm_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kpbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
